// File: sv/dss_pkg.sv
// Shared types and constants for the dock seek state machine.
// Holds the phase, beacon and wheel command codes, the register map and the word layouts.
// Depends on nothing; every other file imports it.
package dss_pkg;

  // Field widths fixed by the word formats.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DIST_W  = 12;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned BEACON_W = 2;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;

  // Beacon direction codes.
  typedef enum logic [BEACON_W-1:0] {
    BC_NONE   = 2'd0,
    BC_LEFT   = 2'd1,
    BC_RIGHT  = 2'd2,
    BC_CENTRE = 2'd3
  } beacon_t;

  // Wheel command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_HOLD  = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_FWD   = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_RIGHT = 3'd4
  } wheel_cmd_t;

  // Seek phases, one-hot.
  typedef enum logic [6:0] {
    PH_DECIDE  = 7'b0000001,
    PH_SEARCH  = 7'b0000010,
    PH_ADVANCE = 7'b0000100,
    PH_LISTEN  = 7'b0001000,
    PH_PUSH    = 7'b0010000,
    PH_LEFT    = 7'b0100000,
    PH_RIGHT   = 7'b1000000
  } phase_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STOP_DISTANCE = 3'd0,
    REG_FLIP_WINDOW   = 3'd1,
    REG_PUSH          = 3'd2,
    REG_SEARCH        = 3'd3,
    REG_ADVANCE       = 3'd4,
    REG_CORRECT       = 3'd5,
    REG_LISTEN        = 3'd6
  } reg_index_t;

  // Register values after reset.
  localparam logic [DIST_W-1:0] STOP_DISTANCE_RST = 12'd80;
  localparam logic [MS_W-1:0]   FLIP_WINDOW_RST   = 16'd500;
  localparam logic [MS_W-1:0]   PUSH_RST          = 16'd350;
  localparam logic [MS_W-1:0]   SEARCH_RST        = 16'd160;
  localparam logic [MS_W-1:0]   ADVANCE_RST       = 16'd650;
  localparam logic [MS_W-1:0]   CORRECT_RST       = 16'd80;
  localparam logic [MS_W-1:0]   LISTEN_RST        = 16'd220;

  typedef struct packed {
    logic [DIST_W-1:0] stop_distance;
    logic [MS_W-1:0]   flip_window_ms;
    logic [MS_W-1:0]   push_ms;
    logic [MS_W-1:0]   search_ms;
    logic [MS_W-1:0]   advance_ms;
    logic [MS_W-1:0]   correct_ms;
    logic [MS_W-1:0]   listen_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [DIST_W-1:0] front_left;
    logic [DIST_W-1:0] front_right;
    beacon_t           beacon;
  } item_t;

  typedef struct packed {
    wheel_cmd_t wheel_cmd;
    logic       arrived;
    logic       clear_beacon;
  } result_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] phase_start;
    beacon_t           last_direction;
    beacon_t           last_beacon;
    logic [TIME_W-1:0] last_beacon_time;
  } seek_state_t;

endpackage

// File: sv/dock_seek_state_machine.sv
// Top level of the dock seek state machine: stream ports, input and result registers.
// Instantiates dss_cfg_regs and dss_core; uses dss_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   in_     | slave     | in_tvalid / in_tready   | in_tdata: now_ms, front_left, front_right, beacon
//   out_    | master    | out_tvalid / out_tready | out_tdata: wheel_cmd, arrived, clear_beacon
//   cfg_    | slave     | cfg_valid / cfg_ready   | cfg_addr register index, cfg_data value
//
// Each word is captured in the input register and then in the result register, with the
// combinational decision logic between the two; one word per cycle is sustained while
// out_tready stays high. The seek state updates as a word leaves the input register. Reset
// is synchronous, active low, and empties both registers. A stall on out_tready backs up
// through the input register; cfg writes are always taken.
module dock_seek_state_machine
  import dss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // [31:0] now_ms, [43:32] front_left, [55:44] front_right, [57:56] beacon, [63:58] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] wheel_cmd, [3] arrived, [4] clear_beacon, [7:5] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [MS_W-1:0]       cfg_data
);

  logic    s1_v_r, s1_v_nxt;
  item_t   item_r;
  logic    out_v_r, out_v_nxt;
  result_t out_r;
  result_t step_res;
  cfg_t    cfg;
  logic    in_fire;
  logic    s1_adv;

  // Handshake: the input register moves on whenever the result register is free or draining.
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_v_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    out_v_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.now_ms      <= in_tdata[31:0];
      item_r.front_left  <= in_tdata[43:32];
      item_r.front_right <= in_tdata[55:44];
      item_r.beacon      <= beacon_t'(in_tdata[57:56]);
    end
    if (s1_adv) begin
      out_r <= step_res;
    end
  end

  dss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  dss_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (item_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_r.clear_beacon, out_r.arrived, out_r.wheel_cmd};

  // A word held in the input register survives a stalled output.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r)
    else $error("input word dropped under stall");

  // Every word that leaves the input register shows up as a result.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("processed word produced no result");

  // Reset empties both registers.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s1_v_r)
    else $error("registers not empty after reset");

endmodule

// File: sv/dss_cfg_regs.sv
// Configuration register file for the dock seek state machine.
// Seven timing and distance registers written over the cfg port; uses dss_pkg.
module dss_cfg_regs
  import dss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_ADDR_W-1:0] wr_addr,
  input  logic [MS_W-1:0]       wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; an index past the register list is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_index_t'(wr_addr))
        REG_STOP_DISTANCE: cfg_nxt.stop_distance  = wr_data[DIST_W-1:0];
        REG_FLIP_WINDOW:   cfg_nxt.flip_window_ms = wr_data;
        REG_PUSH:          cfg_nxt.push_ms        = wr_data;
        REG_SEARCH:        cfg_nxt.search_ms      = wr_data;
        REG_ADVANCE:       cfg_nxt.advance_ms     = wr_data;
        REG_CORRECT:       cfg_nxt.correct_ms     = wr_data;
        REG_LISTEN:        cfg_nxt.listen_ms      = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Registers come out of reset at their documented defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_distance  <= STOP_DISTANCE_RST;
      cfg_r.flip_window_ms <= FLIP_WINDOW_RST;
      cfg_r.push_ms        <= PUSH_RST;
      cfg_r.search_ms      <= SEARCH_RST;
      cfg_r.advance_ms     <= ADVANCE_RST;
      cfg_r.correct_ms     <= CORRECT_RST;
      cfg_r.listen_ms      <= LISTEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/dss_core.sv
// Seek state and per-tick decision logic of the dock seek state machine.
// Holds phase, timers and beacon history; computes one result per word. Uses dss_pkg.
module dss_core
  import dss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  seek_state_t state_r;
  seek_state_t state_nxt;
  result_t     res;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] beacon_gap;
  logic [MS_W-1:0]   limit;
  logic              timer_done;
  logic              flip;
  logic              likely;
  logic              seen;
  logic              near_base;
  logic [DIST_W-1:0] nearest;

  // Timer of the current phase: one subtract, limit picked by phase.
  always_comb begin
    elapsed = item.now_ms - state_r.phase_start;
    unique case (state_r.phase)
      PH_SEARCH:          limit = cfg.search_ms;
      PH_ADVANCE:         limit = cfg.advance_ms;
      PH_LISTEN:          limit = cfg.listen_ms;
      PH_PUSH:            limit = cfg.push_ms;
      PH_LEFT, PH_RIGHT:  limit = cfg.correct_ms;
      default:            limit = '0;
    endcase
    timer_done = elapsed > {{(TIME_W-MS_W){1'b0}}, limit};
  end

  // A left/right flip inside the window means the base is likely dead ahead.
  always_comb begin
    seen       = item.beacon != BC_NONE;
    beacon_gap = item.now_ms - state_r.last_beacon_time;
    flip       = (state_r.last_beacon == BC_LEFT && item.beacon == BC_RIGHT) ||
                 (state_r.last_beacon == BC_RIGHT && item.beacon == BC_LEFT);
    likely     = flip && (beacon_gap < {{(TIME_W-MS_W){1'b0}}, cfg.flip_window_ms});
    nearest    = (item.front_left < item.front_right) ? item.front_left : item.front_right;
    near_base  = seen && (nearest < cfg.stop_distance);
  end

  // Phase transitions and the wheel command for this tick.
  always_comb begin
    state_nxt = state_r;
    res.wheel_cmd    = CMD_HOLD;
    res.arrived      = 1'b0;
    res.clear_beacon = 1'b0;

    if (seen) begin
      state_nxt.last_beacon      = item.beacon;
      state_nxt.last_beacon_time = item.now_ms;
    end

    if (state_r.phase == PH_PUSH) begin
      res.wheel_cmd = CMD_FWD;
      if (timer_done) begin
        res.wheel_cmd            = CMD_STOP;
        res.arrived              = 1'b1;
        res.clear_beacon         = 1'b1;
        state_nxt.phase          = PH_DECIDE;
        state_nxt.last_direction = BC_NONE;
        state_nxt.last_beacon    = BC_NONE;
      end
    end else if (near_base) begin
      res.wheel_cmd         = CMD_STOP;
      state_nxt.phase       = PH_PUSH;
      state_nxt.phase_start = item.now_ms;
    end else begin
      if (seen) begin
        state_nxt.last_direction = item.beacon;
      end
      unique case (state_r.phase)
        PH_DECIDE: begin
          state_nxt.phase_start = item.now_ms;
          priority if (item.beacon == BC_CENTRE || likely) begin
            res.clear_beacon = 1'b1;
            state_nxt.phase  = PH_ADVANCE;
          end else if (item.beacon == BC_LEFT) begin
            res.clear_beacon = 1'b1;
            state_nxt.phase  = PH_LEFT;
          end else if (item.beacon == BC_RIGHT) begin
            res.clear_beacon = 1'b1;
            state_nxt.phase  = PH_RIGHT;
          end else if (state_r.last_direction == BC_LEFT) begin
            state_nxt.phase  = PH_LEFT;
          end else if (state_r.last_direction == BC_RIGHT) begin
            state_nxt.phase  = PH_RIGHT;
          end else begin
            state_nxt.phase  = PH_SEARCH;
          end
        end
        PH_SEARCH: begin
          res.wheel_cmd = CMD_RIGHT;
          if (seen || timer_done) begin
            res.wheel_cmd         = CMD_STOP;
            state_nxt.phase       = PH_LISTEN;
            state_nxt.phase_start = item.now_ms;
          end
        end
        PH_ADVANCE: begin
          res.wheel_cmd = CMD_FWD;
          if (timer_done) begin
            res.wheel_cmd         = CMD_STOP;
            state_nxt.phase       = PH_LISTEN;
            state_nxt.phase_start = item.now_ms;
          end
        end
        PH_LEFT, PH_RIGHT: begin
          res.wheel_cmd = (state_r.phase == PH_LEFT) ? CMD_LEFT : CMD_RIGHT;
          if (timer_done || item.beacon == BC_CENTRE) begin
            res.wheel_cmd         = CMD_STOP;
            state_nxt.phase       = PH_LISTEN;
            state_nxt.phase_start = item.now_ms;
          end
        end
        PH_LISTEN: begin
          res.wheel_cmd = CMD_STOP;
          if (timer_done) begin
            state_nxt.phase = PH_DECIDE;
          end
        end
        default: begin
          state_nxt.phase = state_r.phase;
        end
      endcase
    end
  end

  // State advances once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase            <= PH_DECIDE;
      state_r.phase_start      <= '0;
      state_r.last_direction   <= BC_NONE;
      state_r.last_beacon      <= BC_NONE;
      state_r.last_beacon_time <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  assign result = res;

  // An arrival always ends the push and returns to the decide phase.
  a_arrive_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.arrived |=> state_r.phase == PH_DECIDE && state_r.last_beacon == BC_NONE)
    else $error("arrival did not return to decide");

  // Arrival and the stop command go together with a detector clear.
  a_arrive_stops: assert property (@(posedge clk) disable iff (!rst_n)
    res.arrived |-> res.wheel_cmd == CMD_STOP && res.clear_beacon)
    else $error("arrival without stop and clear");

  // Entering the push restarts its timer at the tick time.
  a_push_entry: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && state_r.phase != PH_PUSH && near_base
    |=> state_r.phase == PH_PUSH && state_r.phase_start == $past(item.now_ms))
    else $error("push entry lost its start time");

endmodule
